// ----- rtl/core/jsu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the string unescaper: result kinds, error
// codes, one result beat and the bundle of beats that one input byte causes.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_BEATS   = 4;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NO_QUOTE = 3'd1,
		ERR_CONTROL  = 3'd2,
		ERR_BAD_HEX  = 3'd3,
		ERR_BAD_ESC  = 3'd4,
		ERR_ENDED    = 3'd5
	} err_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		err_t       error_code;
	} result_t;

	typedef struct packed {
		logic [2:0]                  cnt;
		result_t [MAX_BEATS-1:0]     r;
	} bundle_t;

endpackage
`default_nettype wire

// ----- rtl/core/jsu_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_if
// Valid/ready channels of the unescaper: raw text beats in, decoded beats out.
// ----------------------------------------------------------------------------
interface jsu_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       start_req;
	logic       end_of_input;

	modport source (output valid, byte_in, start_req, end_of_input, input ready);
	modport sink   (input valid, byte_in, start_req, end_of_input, output ready);
endinterface

interface jsu_dec_if;
	logic            valid;
	logic            ready;
	jsu_pkg::kind_t  kind;
	logic [7:0]      data_byte;
	jsu_pkg::err_t   error_code;
	logic            last;

	modport source (output valid, kind, data_byte, error_code, last, input ready);
	modport sink   (input valid, kind, data_byte, error_code, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/jsu_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw beats, tracks the literal state and builds the bundle of
// decoded beats that each byte causes.
// ----------------------------------------------------------------------------
module jsu_front (
	input  wire                clk,
	input  wire                arst_n,
	jsu_raw_if.sink            raw,
	input  wire                full,
	output logic               push,
	output jsu_pkg::bundle_t   bundle
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX  = 3'd3,
		PH_DONE = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	phase_t      phase_q, ph, ph_n;
	logic [15:0] hex_q, hv, hv_n;
	logic [1:0]  hcnt_q, hc, hc_n;
	logic [15:0] pend_q, pc, pc_n;
	logic        pvld_q, pv, pv_n;
	logic [15:0] hv_dig;
	logic [3:0]  dig;
	logic        dig_ok;
	logic        accept;
	bundle_t     b;

	function automatic bundle_t add(bundle_t bi, kind_t k, logic [7:0] d, err_t e);
		bundle_t bo;
		bo = bi;
		if (bi.cnt < 3'(MAX_BEATS)) begin
			bo.r[bi.cnt[1:0]] = '{kind: k, data_byte: d, error_code: e};
			bo.cnt = bi.cnt + 3'd1;
		end
		return bo;
	endfunction

	function automatic bundle_t enc(bundle_t bi, logic [20:0] cp);
		bundle_t bo;
		bo = bi;
		if (cp < 21'h80) begin
			bo = add(bo, KIND_DATA, cp[7:0], ERR_NONE);
		end else if (cp < 21'h800) begin
			bo = add(bo, KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
			bo = add(bo, KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
		end else if (cp < 21'h10000) begin
			bo = add(bo, KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
			bo = add(bo, KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
			bo = add(bo, KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
		end else begin
			bo = add(bo, KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
			bo = add(bo, KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
			bo = add(bo, KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
			bo = add(bo, KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
		end
		return bo;
	endfunction

	assign raw.ready = !full;
	assign accept    = raw.valid && raw.ready;

	always_comb begin
		dig_ok = 1'b1;
		dig    = 4'd0;
		if (raw.byte_in inside {[8'h30:8'h39]}) begin
			dig = raw.byte_in[3:0];
		end else if (raw.byte_in inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			dig = raw.byte_in[3:0] + 4'd9;
		end else begin
			dig_ok = 1'b0;
		end
	end

	always_comb begin
		ph = raw.start_req ? PH_IDLE : phase_q;
		hv = raw.start_req ? 16'd0 : hex_q;
		hc = raw.start_req ? 2'd0 : hcnt_q;
		pc = raw.start_req ? 16'd0 : pend_q;
		pv = raw.start_req ? 1'b0 : pvld_q;
		ph_n = ph;
		hv_n = hv;
		hc_n = hc;
		pc_n = pc;
		pv_n = pv;
		hv_dig = {hv[11:0], dig};
		b = '0;
		if (raw.end_of_input) begin
			if (ph == PH_IDLE || ph == PH_STR || ph == PH_ESC || ph == PH_HEX) begin
				b = add(b, KIND_ERROR, 8'd0, (ph == PH_HEX) ? ERR_BAD_HEX : ERR_ENDED);
				ph_n = PH_ERR;
			end
		end else begin
			case (ph)
				PH_IDLE: begin
					if (raw.byte_in == 8'h22) begin
						ph_n = PH_STR;
					end else begin
						b = add(b, KIND_ERROR, 8'd0, ERR_NO_QUOTE);
						ph_n = PH_ERR;
					end
				end
				PH_STR: begin
					if (raw.byte_in == 8'h22) begin
						if (pv) b = enc(b, {5'd0, pc});
						b = add(b, KIND_DONE, 8'd0, ERR_NONE);
						pv_n = 1'b0;
						ph_n = PH_DONE;
					end else if (raw.byte_in <= 8'h1f) begin
						b = add(b, KIND_ERROR, 8'd0, ERR_CONTROL);
						ph_n = PH_ERR;
					end else if (raw.byte_in == 8'h5c) begin
						ph_n = PH_ESC;
					end else begin
						if (pv) b = enc(b, {5'd0, pc});
						b = add(b, KIND_DATA, raw.byte_in, ERR_NONE);
						pv_n = 1'b0;
					end
				end
				PH_ESC: begin
					if (raw.byte_in == 8'h75) begin
						hv_n = 16'd0;
						hc_n = 2'd0;
						ph_n = PH_HEX;
					end else if (raw.byte_in inside {8'h62, 8'h66, 8'h6e, 8'h72, 8'h74,
					                                 8'h22, 8'h5c, 8'h2f}) begin
						if (pv) b = enc(b, {5'd0, pc});
						case (raw.byte_in)
							8'h62:   b = add(b, KIND_DATA, 8'h08, ERR_NONE);
							8'h66:   b = add(b, KIND_DATA, 8'h0c, ERR_NONE);
							8'h6e:   b = add(b, KIND_DATA, 8'h0a, ERR_NONE);
							8'h72:   b = add(b, KIND_DATA, 8'h0d, ERR_NONE);
							8'h74:   b = add(b, KIND_DATA, 8'h09, ERR_NONE);
							default: b = add(b, KIND_DATA, raw.byte_in, ERR_NONE);
						endcase
						pv_n = 1'b0;
						ph_n = PH_STR;
					end else begin
						b = add(b, KIND_ERROR, 8'd0, ERR_BAD_ESC);
						ph_n = PH_ERR;
					end
				end
				PH_HEX: begin
					if (!dig_ok) begin
						b = add(b, KIND_ERROR, 8'd0, ERR_BAD_HEX);
						ph_n = PH_ERR;
					end else if (hc != 2'd3) begin
						hv_n = hv_dig;
						hc_n = hc + 2'd1;
					end else begin
						hv_n = 16'd0;
						hc_n = 2'd0;
						ph_n = PH_STR;
						if (pv && pc inside {[16'hd800:16'hdbff]} &&
						    hv_dig inside {[16'hdc00:16'hdfff]}) begin
							b = enc(b, {1'b0, pc[9:0], hv_dig[9:0]} + 21'h10000);
							pv_n = 1'b0;
							pc_n = 16'd0;
						end else begin
							if (pv) b = enc(b, {5'd0, pc});
							pc_n = hv_dig;
							pv_n = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (ph_n == PH_ERR) begin
			pv_n = 1'b0;
			pc_n = 16'd0;
			hv_n = 16'd0;
			hc_n = 2'd0;
		end
	end

	assign push   = accept && (b.cnt != 3'd0);
	assign bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= 16'd0;
			hcnt_q  <= 2'd0;
			pend_q  <= 16'd0;
			pvld_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= ph_n;
			hex_q   <= hv_n;
			hcnt_q  <= hc_n;
			pend_q  <= pc_n;
			pvld_q  <= pv_n;
		end
	end

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !raw.start_req && phase_q == PH_ERR) |-> !push)
		else $error("beats after error");
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE || phase_q == PH_ERR) |-> !pvld_q)
		else $error("pending code outside string");

endmodule
`default_nettype wire

// ----- rtl/core/jsu_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// Short FIFO of beat bundles between the front and back parts.
// ----------------------------------------------------------------------------
module jsu_queue #(
	parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  wire jsu_pkg::bundle_t   wr_data,
	input  wire                     pop,
	output jsu_pkg::bundle_t        head,
	output logic                    full,
	output logic                    empty
);
	import jsu_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	bundle_t         mem_q [Depth];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == CW'(Depth));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)  rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/jsu_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Drains bundles one beat a cycle, unless dec.ready stalls, into the output
// register and marks the final beat of each bundle.
// ----------------------------------------------------------------------------
module jsu_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire jsu_pkg::bundle_t   head,
	input  wire                     empty,
	output logic                    pop,
	jsu_dec_if.source               dec
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic       ovld_q;
	logic       load;
	logic       fin;
	result_t    cur;

	assign load = !ovld_q || dec.ready;
	assign cur  = head.r[idx_q];
	assign fin  = ({1'b0, idx_q} == head.cnt - 3'd1);
	assign pop  = load && !empty && fin;

	assign dec.valid = ovld_q;

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			dec.kind       <= cur.kind;
			dec.data_byte  <= cur.data_byte;
			dec.error_code <= cur.error_code;
			dec.last       <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			ovld_q <= !empty;
			if (!empty) idx_q <= fin ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_nonempty_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (head.cnt != 3'd0 && head.cnt <= 3'(MAX_BEATS)))
		else $error("bad bundle count");
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dec.valid && dec.kind != KIND_DATA) |-> dec.last)
		else $error("end or error beat not last");
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dec.valid && dec.kind != KIND_DATA) |-> dec.data_byte == 8'd0)
		else $error("data on non-data beat");
	a_idx_reset: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0) else $error("index not rewound");

endmodule
`default_nettype wire

// ----- rtl/core/json_string_unescape_utf8.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes one double-quoted string literal into UTF-8.
//
// raw: one beat per text byte (byte_in, start_req, end_of_input).
// dec: decoded beats (kind, data_byte, error_code, last); last marks the
//   final beat caused by one raw beat. Raw beats that cause nothing give no
//   dec beat.
// Path: a taken raw beat's bundle is queued, then its beats pass the output
//   register; further beats (up to three more) follow one per cycle.
// Throughput: one raw beat per cycle, one dec beat per cycle. raw.ready is
//   the queue's free flag, so a burst of multi-byte escapes or a stalled
//   receiver fills the queue (QueueDepth bundles) and then holds raw off.
// Stall: the output register holds its beat until dec.ready.
// Reset: clears the literal state to idle and empties the queue; an error
//   state stays until the next start_req.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
	parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	jsu_raw_if.sink    raw,
	jsu_dec_if.source  dec
);
	import jsu_pkg::*;

	bundle_t push_bundle, head;
	logic    push, pop, full, empty;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.full   (full),
		.push   (push),
		.bundle (push_bundle)
	);

	jsu_queue #(.Depth(QueueDepth)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_bundle),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.dec    (dec)
	);

endmodule
`default_nettype wire

// ----- tb/json_string_unescape_utf8_tb.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Drives raw literal text into the unescaper and checks every decoded beat
// against a predictor of the literal decoder kept in the bench. Directed
// literals hit the escape, surrogate and error paths; random literals,
// mostly well formed with broken endings and noise mixed in, follow. Both
// channels idle at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;

	import jsu_pkg::*;

	localparam int          RANDOM_BEATS = 420;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 200;
	localparam logic [7:0]  CH_QUOTE     = 8'h22;
	localparam logic [7:0]  CH_BSLASH    = 8'h5C;
	localparam logic [7:0]  CH_U         = 8'h75;

	typedef enum logic [2:0] {
		LIT_IDLE,
		LIT_STRING,
		LIT_ESCAPE,
		LIT_HEX,
		LIT_DONE,
		LIT_ERROR
	} lit_phase_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       start_req;
		logic       end_of_input;
	} raw_beat_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		err_t       error_code;
		logic       last;
	} dec_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic       raw_valid = 1'b0;
	logic [7:0] raw_byte  = 8'h00;
	logic       raw_start = 1'b0;
	logic       raw_eoi   = 1'b0;
	logic       dec_ready = 1'b0;

	logic [31:0] cycle_count = '0;
	int          error_count = 0;
	int          src_gap     = 0;
	int          snk_stall   = 0;
	int          random_beats = 0;

	raw_beat_t raw_pending[$];
	raw_beat_t raw_next;
	dec_beat_t dec_expected[$];
	dec_beat_t step_beats[$];

	lit_phase_t  lit_phase    = LIT_IDLE;
	logic [15:0] hex_acc      = '0;
	logic [1:0]  hex_cnt      = '0;
	logic [15:0] pend_code    = '0;
	logic        pend_valid   = 1'b0;

	wire calm = (cycle_count[8:7] == 2'b11);

	jsu_raw_if raw_ch ();
	jsu_dec_if dec_ch ();

	assign raw_ch.valid        = raw_valid;
	assign raw_ch.byte_in      = raw_byte;
	assign raw_ch.start_req    = raw_start;
	assign raw_ch.end_of_input = raw_eoi;
	assign dec_ch.ready        = dec_ready;

	json_string_unescape_utf8 i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_ch),
		.dec    (dec_ch)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Literal decoder predictor
	// ------------------------------------------------------------------
	function automatic void emit(kind_t k, logic [7:0] d, err_t e);
		dec_beat_t nb;
		nb.kind       = k;
		nb.data_byte  = d;
		nb.error_code = e;
		nb.last       = 1'b0;
		step_beats.insert(step_beats.size(), nb);
	endfunction

	function automatic void emit_utf8(logic [20:0] cp);
		if (cp < 21'h80) begin
			emit(KIND_DATA, cp[7:0], ERR_NONE);
		end else if (cp < 21'h800) begin
			emit(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
			emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
		end else if (cp < 21'h10000) begin
			emit(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
			emit(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
			emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
		end else begin
			emit(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
			emit(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
			emit(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
			emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
		end
	endfunction

	function automatic void flush_pending();
		if (pend_valid)
			emit_utf8({5'd0, pend_code});
		pend_valid = 1'b0;
		pend_code  = '0;
	endfunction

	function automatic void clear_literal();
		lit_phase  = LIT_IDLE;
		hex_acc    = '0;
		hex_cnt    = '0;
		pend_code  = '0;
		pend_valid = 1'b0;
	endfunction

	function automatic void raise_error(err_t e);
		emit(KIND_ERROR, 8'h00, e);
		clear_literal();
		lit_phase = LIT_ERROR;
	endfunction

	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b0, c[3:0]};
		if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	function automatic bit is_escape_char(logic [7:0] c);
		return c == "b" || c == "f" || c == "n" || c == "r" || c == "t" ||
			c == CH_QUOTE || c == CH_BSLASH || c == "/";
	endfunction

	function automatic void decode_beat(raw_beat_t b);
		logic [4:0]  nib;
		logic [15:0] cp;
		logic [20:0] full;
		logic [7:0]  esc;
		dec_beat_t   nb;
		step_beats.delete();
		if (b.start_req)
			clear_literal();
		if (b.end_of_input) begin
			if (lit_phase == LIT_IDLE || lit_phase == LIT_STRING || lit_phase == LIT_ESCAPE)
				raise_error(ERR_ENDED);
			else if (lit_phase == LIT_HEX)
				raise_error(ERR_BAD_HEX);
		end else begin
			case (lit_phase)
				LIT_IDLE: begin
					if (b.byte_in == CH_QUOTE)
						lit_phase = LIT_STRING;
					else
						raise_error(ERR_NO_QUOTE);
				end
				LIT_STRING: begin
					if (b.byte_in == CH_QUOTE) begin
						flush_pending();
						emit(KIND_DONE, 8'h00, ERR_NONE);
						lit_phase = LIT_DONE;
					end else if (b.byte_in <= 8'h1F) begin
						raise_error(ERR_CONTROL);
					end else if (b.byte_in == CH_BSLASH) begin
						lit_phase = LIT_ESCAPE;
					end else begin
						flush_pending();
						emit(KIND_DATA, b.byte_in, ERR_NONE);
					end
				end
				LIT_ESCAPE: begin
					if (b.byte_in == CH_U) begin
						hex_acc   = '0;
						hex_cnt   = '0;
						lit_phase = LIT_HEX;
					end else if (is_escape_char(b.byte_in)) begin
						case (b.byte_in)
							"b":     esc = 8'h08;
							"f":     esc = 8'h0C;
							"n":     esc = 8'h0A;
							"r":     esc = 8'h0D;
							"t":     esc = 8'h09;
							default: esc = b.byte_in;
						endcase
						flush_pending();
						emit(KIND_DATA, esc, ERR_NONE);
						lit_phase = LIT_STRING;
					end else begin
						raise_error(ERR_BAD_ESC);
					end
				end
				LIT_HEX: begin
					nib = hex_nibble(b.byte_in);
					if (nib[4]) begin
						raise_error(ERR_BAD_HEX);
					end else begin
						hex_acc = {hex_acc[11:0], nib[3:0]};
						if (hex_cnt != 2'd3) begin
							hex_cnt = hex_cnt + 2'd1;
						end else begin
							cp        = hex_acc;
							hex_acc   = '0;
							hex_cnt   = '0;
							lit_phase = LIT_STRING;
							if (pend_valid && pend_code >= 16'hD800 && pend_code <= 16'hDBFF &&
								cp >= 16'hDC00 && cp <= 16'hDFFF) begin
								full = {1'b0, pend_code[9:0], cp[9:0]} + 21'h10000;
								pend_valid = 1'b0;
								pend_code  = '0;
								emit_utf8(full);
							end else begin
								flush_pending();
								pend_code  = cp;
								pend_valid = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
		for (int i = 0; i < step_beats.size(); i++) begin
			nb      = step_beats[i];
			nb.last = (i == step_beats.size() - 1);
			dec_expected.insert(dec_expected.size(), nb);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_raw(logic [7:0] c, logic s, logic e);
		raw_beat_t nb;
		nb.byte_in      = c;
		nb.start_req    = s;
		nb.end_of_input = e;
		raw_pending.insert(raw_pending.size(), nb);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + n;
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	task automatic push_hex_escape(logic [15:0] cp);
		push_raw(CH_BSLASH, 1'b0, 1'b0);
		push_raw(CH_U, 1'b0, 1'b0);
		push_raw(hex_char(cp[15:12]), 1'b0, 1'b0);
		push_raw(hex_char(cp[11:8]), 1'b0, 1'b0);
		push_raw(hex_char(cp[7:4]), 1'b0, 1'b0);
		push_raw(hex_char(cp[3:0]), 1'b0, 1'b0);
	endtask

	task automatic push_token();
		int          sel;
		logic [7:0]  c;
		logic [15:0] cp;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			c = 8'($urandom_range(8'h20, 8'h7E));
			while (c == CH_QUOTE || c == CH_BSLASH)
				c = 8'($urandom_range(8'h20, 8'h7E));
			push_raw(c, 1'b0, 1'b0);
		end else if (sel < 50) begin
			push_raw(8'($urandom_range(8'h80, 8'hFF)), 1'b0, 1'b0);
		end else if (sel < 62) begin
			c = 8'($urandom_range(0, 255));
			while (!is_escape_char(c))
				c = 8'($urandom_range(0, 255));
			push_raw(CH_BSLASH, 1'b0, 1'b0);
			push_raw(c, 1'b0, 1'b0);
		end else begin
			case ($urandom_range(0, 6))
				0: cp = 16'($urandom_range(16'h0000, 16'h007F));
				1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
				2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
				3: cp = 16'($urandom_range(16'hD800, 16'hDBFF));
				4: cp = 16'($urandom_range(16'hDC00, 16'hDFFF));
				5: cp = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
				default: begin
					push_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
					cp = 16'($urandom_range(16'hDC00, 16'hDFFF));
				end
			endcase
			push_hex_escape(cp);
		end
	endtask

	task automatic push_literal();
		int         n_tok;
		int         ending;
		int         n_dig;
		logic [7:0] c;
		push_raw(CH_QUOTE, 1'b1, 1'b0);
		n_tok = $urandom_range(0, 10);
		for (int t = 0; t < n_tok; t++)
			push_token();
		ending = $urandom_range(0, 99);
		if (ending < 70) begin
			push_raw(CH_QUOTE, 1'b0, 1'b0);
		end else if (ending < 76) begin
			push_raw(8'($urandom_range(8'h00, 8'h1F)), 1'b0, 1'b0);
		end else if (ending < 82) begin
			c = 8'($urandom_range(0, 255));
			while (is_escape_char(c) || c == CH_U)
				c = 8'($urandom_range(0, 255));
			push_raw(CH_BSLASH, 1'b0, 1'b0);
			push_raw(c, 1'b0, 1'b0);
		end else if (ending < 88) begin
			push_raw(CH_BSLASH, 1'b0, 1'b0);
			push_raw(CH_U, 1'b0, 1'b0);
			n_dig = $urandom_range(0, 3);
			for (int d = 0; d < n_dig; d++)
				push_raw(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b0);
			if ($urandom_range(0, 1)) begin
				c = 8'($urandom_range(0, 255));
				while (hex_nibble(c) < 5'h10)
					c = 8'($urandom_range(0, 255));
				push_raw(c, 1'b0, 1'b0);
			end else begin
				push_raw(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			end
		end else if (ending < 94) begin
			push_raw(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			push_raw(CH_BSLASH, 1'b0, 1'b0);
			push_raw(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	task automatic push_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			push_raw(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 7) == 0);
	endtask

	task automatic push_trailing();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			push_raw(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic check_dec_beat();
		dec_beat_t want;
		if (dec_expected.size() == 0) begin
			$display("%0t: unexpected beat: expected none, actual kind=%0d data=%02h err=%0d last=%0b",
				$time, dec_ch.kind, dec_ch.data_byte, dec_ch.error_code, dec_ch.last);
			error_count++;
		end else begin
			want = dec_expected.pop_front();
			check_field("kind", 8'(want.kind), 8'(dec_ch.kind));
			check_field("data_byte", want.data_byte, dec_ch.data_byte);
			check_field("error_code", 8'(want.error_code), 8'(dec_ch.error_code));
			check_field("last", 8'(want.last), 8'(dec_ch.last));
		end
	endtask

	// ------------------------------------------------------------------
	// Raw driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_valid <= 1'b0;
			raw_byte  <= 8'h00;
			raw_start <= 1'b0;
			raw_eoi   <= 1'b0;
			src_gap = 0;
		end else begin
			if (raw_valid && raw_ch.ready)
				decode_beat({raw_byte, raw_start, raw_eoi});
			if (!raw_valid || raw_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					raw_valid <= 1'b0;
				end else if (raw_pending.size() > 0) begin
					raw_next = raw_pending.pop_front();
					raw_byte  <= raw_next.byte_in;
					raw_start <= raw_next.start_req;
					raw_eoi   <= raw_next.end_of_input;
					raw_valid <= 1'b1;
					if (!calm && $urandom_range(0, 3) == 0)
						src_gap = pick_gap();
				end else begin
					raw_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Decoded monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_ready <= 1'b0;
			snk_stall = 0;
		end else begin
			if (dec_ch.valid && dec_ready)
				check_dec_beat();
			if (snk_stall > 0) begin
				snk_stall--;
				dec_ready <= 1'b0;
			end else begin
				dec_ready <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0)
					snk_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int mark;
		// well-formed literal: high byte, surrogate pair at its extremes, escape
		push_raw(CH_QUOTE, 1'b1, 1'b0);
		push_raw(8'hFF, 1'b0, 1'b0);
		push_hex_escape(16'hDBFF);
		push_hex_escape(16'hDC00);
		push_raw(CH_BSLASH, 1'b0, 1'b0);
		push_raw("/", 1'b0, 1'b0);
		push_raw(CH_QUOTE, 1'b0, 1'b0);
		push_raw(8'h00, 1'b0, 1'b0);
		// error paths
		push_raw("x", 1'b1, 1'b0);
		push_raw(8'h00, 1'b1, 1'b1);
		push_raw(CH_QUOTE, 1'b1, 1'b0);
		push_raw(8'h00, 1'b0, 1'b0);
		push_raw(CH_QUOTE, 1'b1, 1'b0);
		push_raw(CH_BSLASH, 1'b0, 1'b0);
		push_raw("%", 1'b0, 1'b0);
		push_raw(CH_QUOTE, 1'b1, 1'b0);
		push_raw(CH_BSLASH, 1'b0, 1'b0);
		push_raw(CH_U, 1'b0, 1'b0);
		push_raw("G", 1'b0, 1'b0);

		while (random_beats < RANDOM_BEATS) begin
			mark = raw_pending.size();
			if ($urandom_range(0, 99) < 85)
				push_literal();
			else
				push_noise();
			if ($urandom_range(0, 3) == 0)
				push_trailing();
			random_beats += raw_pending.size() - mark;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (raw_pending.size() != 0 || raw_valid)
			@(posedge clk);
		while (dec_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
